// ===== hw/rtl/upsc_pkg.sv =====
`timescale 1ns / 1ps

package upsc_pkg;

    localparam int MAX_WIDTH = 1024;
    localparam int ADDR_W    = $clog2(MAX_WIDTH);

    localparam int FACTOR_W = 7;
    localparam int WIDTH_W  = 11;
    localparam int HEIGHT_W = 16;
    localparam int PIXEL_W  = 24;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [FACTOR_W-1:0] FACTOR_MAX = 7'd100;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd2;

    // Opcodes
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_PULL = 1'b1;

    // Result kinds
    localparam logic [1:0] KIND_PIXEL   = 2'd0;
    localparam logic [1:0] KIND_PAD     = 2'd1;
    localparam logic [1:0] KIND_IDLE    = 2'd2;
    localparam logic [1:0] KIND_REFUSED = 2'd3;

    typedef struct packed {
        logic               opcode;
        logic [PIXEL_W-1:0] pixel_in;
    } in_item_t;

    typedef struct packed {
        logic [1:0]         item_kind;
        logic [PIXEL_W-1:0] pixel_out;
        logic               row_end;
        logic               image_end;
    } out_item_t;

    typedef struct packed {
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [PIXEL_W-1:0] wr_data;
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
    } mem_req_t;

    typedef struct packed {
        logic [1:0] kind;
        logic       row_end;
        logic       image_end;
    } res_ctl_t;

endpackage

// ===== hw/rtl/upsc_line_store.sv =====
`timescale 1ns / 1ps

module upsc_line_store (
    input  logic                          aclk,
    input  upsc_pkg::mem_req_t            req,
    output logic [upsc_pkg::PIXEL_W-1:0]  rd_data
);

    logic [upsc_pkg::PIXEL_W-1:0] mem [upsc_pkg::MAX_WIDTH];
    logic [upsc_pkg::PIXEL_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem[req.wr_addr] <= req.wr_data;
        end
    end

    // Read data holds until the next read request, so it stays in step with the result register.
    always_ff @(posedge aclk) begin
        if (req.rd_en) begin
            rd_data_reg <= mem[req.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hw/rtl/upsc_ctrl.sv =====
`timescale 1ns / 1ps

module upsc_ctrl (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            accept,
    input  upsc_pkg::in_item_t              item,
    input  logic [upsc_pkg::FACTOR_W-1:0]   scale_factor,
    input  logic [upsc_pkg::WIDTH_W-1:0]    input_width,
    input  logic [upsc_pkg::HEIGHT_W-1:0]   input_height,
    output upsc_pkg::res_ctl_t              res,
    output upsc_pkg::mem_req_t              mem_req
);

    logic                          replay_reg,      replay_next;
    logic [upsc_pkg::WIDTH_W-1:0]  write_index_reg, write_index_next;
    logic [upsc_pkg::WIDTH_W-1:0]  read_index_reg,  read_index_next;
    logic [upsc_pkg::FACTOR_W-1:0] copy_count_reg,  copy_count_next;
    logic [upsc_pkg::FACTOR_W-1:0] row_repeat_reg,  row_repeat_next;
    logic [1:0]                    pad_count_reg,   pad_count_next;
    logic [upsc_pkg::HEIGHT_W-1:0] rows_done_reg,   rows_done_next;

    logic [upsc_pkg::FACTOR_W-1:0] eff_n;
    logic [upsc_pkg::WIDTH_W-1:0]  eff_w;
    logic [upsc_pkg::HEIGHT_W-1:0] eff_h;
    logic [1:0]                    pad_amt;

    always_comb begin
        if (scale_factor == '0) begin
            eff_n = upsc_pkg::FACTOR_W'(1);
        end else if (scale_factor > upsc_pkg::FACTOR_MAX) begin
            eff_n = upsc_pkg::FACTOR_MAX;
        end else begin
            eff_n = scale_factor;
        end
        if (input_width == '0) begin
            eff_w = upsc_pkg::WIDTH_W'(1);
        end else if (input_width > upsc_pkg::WIDTH_W'(upsc_pkg::MAX_WIDTH)) begin
            eff_w = upsc_pkg::WIDTH_W'(upsc_pkg::MAX_WIDTH);
        end else begin
            eff_w = input_width;
        end
        eff_h = (input_height == '0) ? upsc_pkg::HEIGHT_W'(1) : input_height;
    end

    // Padding is -(3*w*n) mod 4, which equals (w*n) mod 4.
    assign pad_amt = eff_w[1:0] * eff_n[1:0];

    always_comb begin
        replay_next      = replay_reg;
        write_index_next = write_index_reg;
        read_index_next  = read_index_reg;
        copy_count_next  = copy_count_reg;
        row_repeat_next  = row_repeat_reg;
        pad_count_next   = pad_count_reg;
        rows_done_next   = rows_done_reg;

        res.kind      = upsc_pkg::KIND_IDLE;
        res.row_end   = 1'b0;
        res.image_end = 1'b0;

        mem_req.wr_en   = 1'b0;
        mem_req.wr_addr = write_index_reg[upsc_pkg::ADDR_W-1:0];
        mem_req.wr_data = item.pixel_in;
        mem_req.rd_en   = 1'b0;
        mem_req.rd_addr = read_index_reg[upsc_pkg::ADDR_W-1:0];

        if (accept) begin
            if (item.opcode == upsc_pkg::OP_LOAD) begin
                if (replay_reg) begin
                    res.kind = upsc_pkg::KIND_REFUSED;
                end else begin
                    mem_req.wr_en = (write_index_reg <
                                     upsc_pkg::WIDTH_W'(upsc_pkg::MAX_WIDTH));
                    write_index_next = write_index_reg + 1'b1;
                    if (write_index_next >= eff_w) begin
                        write_index_next = '0;
                        read_index_next  = '0;
                        copy_count_next  = '0;
                        row_repeat_next  = '0;
                        pad_count_next   = '0;
                        replay_next      = 1'b1;
                    end
                end
            end else if (replay_reg) begin
                if (read_index_reg < eff_w) begin
                    res.kind        = upsc_pkg::KIND_PIXEL;
                    mem_req.rd_en   = 1'b1;
                    copy_count_next = copy_count_reg + 1'b1;
                    if (copy_count_next >= eff_n) begin
                        copy_count_next = '0;
                        read_index_next = read_index_reg + 1'b1;
                    end
                    if (read_index_next >= eff_w && pad_amt == 2'd0) begin
                        res.row_end = 1'b1;
                    end
                end else begin
                    // Past the row's last pixel, pad items follow until the due padding is given.
                    res.kind       = upsc_pkg::KIND_PAD;
                    pad_count_next = pad_count_reg + 1'b1;
                    if (pad_count_next >= pad_amt) begin
                        res.row_end = 1'b1;
                    end
                end

                if (res.row_end) begin
                    read_index_next = '0;
                    copy_count_next = '0;
                    pad_count_next  = '0;
                    row_repeat_next = row_repeat_reg + 1'b1;
                    if (row_repeat_next >= eff_n) begin
                        row_repeat_next  = '0;
                        replay_next      = 1'b0;
                        write_index_next = '0;
                        rows_done_next   = rows_done_reg + 1'b1;
                        if (rows_done_next >= eff_h) begin
                            rows_done_next = '0;
                            res.image_end  = 1'b1;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            replay_reg      <= 1'b0;
            write_index_reg <= '0;
            read_index_reg  <= '0;
            copy_count_reg  <= '0;
            row_repeat_reg  <= '0;
            pad_count_reg   <= '0;
            rows_done_reg   <= '0;
        end else begin
            replay_reg      <= replay_next;
            write_index_reg <= write_index_next;
            read_index_reg  <= read_index_next;
            copy_count_reg  <= copy_count_next;
            row_repeat_reg  <= row_repeat_next;
            pad_count_reg   <= pad_count_next;
            rows_done_reg   <= rows_done_next;
        end
    end

    a_image_end_closes_row: assert property (@(posedge aclk) disable iff (!aresetn)
        res.image_end |-> res.row_end)
        else $error("image end without row end");

    a_image_end_to_loading: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && res.image_end) |=> (!replay_reg && rows_done_reg == '0))
        else $error("image end did not return to loading");

    a_no_write_in_replay: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_req.wr_en |-> (!replay_reg && !mem_req.rd_en))
        else $error("line store written during replay");

    a_pull_reads_stored_pixel: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_req.rd_en |-> (replay_reg && read_index_reg < eff_w))
        else $error("line store read outside the row");

endmodule

// ===== hw/rtl/integer_pixel_replication_upscaler.sv =====
`timescale 1ns / 1ps

// Channel   Direction  Handshake                Payload
// s_        in         s_valid / s_ready        s_data  (opcode, pixel_in)
// m_        out        m_valid / m_ready        m_data  (item_kind, pixel_out, row_end, image_end)
// cfg_      in         cfg_valid / cfg_ready    cfg_index, cfg_data
//
// Each accepted item gives one result in the next cycle; one item per cycle is sustained
// while m_ready is high, as set by the single result register and the registered line store read.
// A new item is taken whenever the result register is empty or being emptied.
// Synchronous reset clears the counters and sets all three config registers to 1; the line
// store is not cleared, since every read follows a write of the same entry.

module integer_pixel_replication_upscaler (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  upsc_pkg::in_item_t                s_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output upsc_pkg::out_item_t               m_data,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [upsc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [upsc_pkg::CFG_DATA_W-1:0]   cfg_data
);

    logic [upsc_pkg::FACTOR_W-1:0] scale_reg;
    logic [upsc_pkg::WIDTH_W-1:0]  width_reg;
    logic [upsc_pkg::HEIGHT_W-1:0] height_reg;

    logic                          accept;
    upsc_pkg::res_ctl_t            res;
    upsc_pkg::mem_req_t            mem_req;
    logic [upsc_pkg::PIXEL_W-1:0]  rd_data;

    logic                          out_valid_reg;
    upsc_pkg::res_ctl_t            out_ctl_reg;

    assign cfg_ready = 1'b1;
    assign s_ready   = !out_valid_reg || m_ready;
    assign accept    = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scale_reg  <= upsc_pkg::FACTOR_W'(1);
            width_reg  <= upsc_pkg::WIDTH_W'(1);
            height_reg <= upsc_pkg::HEIGHT_W'(1);
        end else if (cfg_valid) begin
            unique case (cfg_index)
                upsc_pkg::CFG_SCALE:  scale_reg  <= cfg_data[upsc_pkg::FACTOR_W-1:0];
                upsc_pkg::CFG_WIDTH:  width_reg  <= cfg_data[upsc_pkg::WIDTH_W-1:0];
                upsc_pkg::CFG_HEIGHT: height_reg <= cfg_data[upsc_pkg::HEIGHT_W-1:0];
                default: ;
            endcase
        end
    end

    upsc_ctrl u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .accept       (accept),
        .item         (s_data),
        .scale_factor (scale_reg),
        .input_width  (width_reg),
        .input_height (height_reg),
        .res          (res),
        .mem_req      (mem_req)
    );

    upsc_line_store u_line_store (
        .aclk    (aclk),
        .req     (mem_req),
        .rd_data (rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (accept) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            out_ctl_reg <= res;
        end
    end

    assign m_valid            = out_valid_reg;
    assign m_data.item_kind   = out_ctl_reg.kind;
    assign m_data.pixel_out   = (out_ctl_reg.kind == upsc_pkg::KIND_PIXEL) ? rd_data : '0;
    assign m_data.row_end     = out_ctl_reg.row_end;
    assign m_data.image_end   = out_ctl_reg.image_end;

    a_pad_is_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.item_kind != upsc_pkg::KIND_PIXEL) |-> (m_data.pixel_out == '0))
        else $error("non-pixel item carries data");

    a_accept_fills_output: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> m_valid)
        else $error("accepted item produced no result");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |-> !accept)
        else $error("result overwritten while stalled");

endmodule
